// File: rtl/cpfc_pkg.sv
// Shared types, constants and lookup functions for the packet frame counter.
package cpfc_pkg;

  localparam int unsigned BitsAfterW   = 14;
  localparam int unsigned FrameCountW  = 12;
  localparam int unsigned StopReasonW  = 2;
  localparam int unsigned SkipW        = 9;
  localparam int unsigned NbLowW       = 45;
  localparam int unsigned NbHighW      = 36;
  localparam int unsigned CfgIndexW    = 1;
  localparam int unsigned CfgDataW     = NbLowW;
  localparam int unsigned MaxPacketBitsDefault = 16384;

  localparam logic [NbLowW-1:0]  NbLowReset  = 45'd15139790935557;
  localparam logic [NbHighW-1:0] NbHighReset = 36'd10732362028;

  localparam logic [CfgIndexW-1:0] CfgNbLow  = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgNbHigh = 1'b1;

  localparam logic [StopReasonW-1:0] StopOutOfBits = 2'd0;
  localparam logic [StopReasonW-1:0] StopTerm      = 2'd1;
  localparam logic [StopReasonW-1:0] StopCorruptWb = 2'd2;
  localparam logic [StopReasonW-1:0] StopBadMode   = 2'd3;

  localparam logic [4:0] NbModeTerm   = 5'd15;
  localparam logic [4:0] NbModeInband = 5'd14;
  localparam logic [4:0] NbModeUser   = 5'd13;
  localparam logic [4:0] NbModeMax    = 5'd8;
  localparam logic [4:0] WbModeLimit  = 5'd5;
  localparam logic [FrameCountW-1:0] FrameCountMax = '1;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_WBMODE,
    PH_NBMODE,
    PH_INBAND,
    PH_USER,
    PH_SKIP,
    PH_STOPPED
  } phase_e;

  typedef struct packed {
    phase_e                  phase;
    logic [4:0]              shift;
    logic [2:0]              bits_left;
    logic [SkipW-1:0]        skip_left;
    logic [1:0]              wide_seen;
    logic [FrameCountW-1:0]  frames;
    logic [StopReasonW-1:0]  stop;
  } parse_state_t;

  localparam parse_state_t ParseReset = '{
    phase: PH_FLAG, shift: '0, bits_left: '0, skip_left: '0,
    wide_seen: '0, frames: '0, stop: '0
  };

  typedef struct packed {
    logic                   packet_bit;
    logic [BitsAfterW-1:0]  bits_after;
  } in_item_t;

  typedef struct packed {
    logic [FrameCountW-1:0] frame_total;
    logic [StopReasonW-1:0] stop_reason;
  } out_item_t;

  function automatic logic [SkipW-1:0] wb_advance(input logic [2:0] mode);
    logic [SkipW-1:0] r;
    case (mode)
      3'd1: r = 9'd32;
      3'd2: r = 9'd108;
      3'd3: r = 9'd188;
      3'd4: r = 9'd348;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [SkipW-1:0] inband_len(input logic [3:0] code);
    logic [SkipW-1:0] r;
    case (code)
      4'd0, 4'd1: r = 9'd1;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: r = 9'd4;
      4'd8, 4'd9: r = 9'd8;
      4'd10, 4'd11: r = 9'd16;
      4'd12, 4'd13: r = 9'd32;
      default: r = 9'd64;
    endcase
    return r;
  endfunction

  function automatic logic [SkipW-1:0] nb_length(input logic [NbLowW-1:0] low,
                                                  input logic [NbHighW-1:0] high,
                                                  input logic [3:0] mode);
    logic [SkipW-1:0] r;
    case (mode)
      4'd0: r = low[8:0];
      4'd1: r = low[17:9];
      4'd2: r = low[26:18];
      4'd3: r = low[35:27];
      4'd4: r = low[44:36];
      4'd5: r = high[8:0];
      4'd6: r = high[17:9];
      4'd7: r = high[26:18];
      4'd8: r = high[35:27];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/cpfc_step.sv
// Next-state logic of the frame parser for one packet bit.
module cpfc_step #(
  parameter int unsigned MaxPacketBits = cpfc_pkg::MaxPacketBitsDefault
) (
  input  logic [cpfc_pkg::NbLowW-1:0]  nb_low_i,
  input  logic [cpfc_pkg::NbHighW-1:0] nb_high_i,
  input  cpfc_pkg::parse_state_t       state_i,
  input  cpfc_pkg::in_item_t           item_i,
  output cpfc_pkg::parse_state_t       state_o,
  output cpfc_pkg::out_item_t          result_o,
  output logic                         last_o
);
  import cpfc_pkg::*;

  localparam int unsigned RemMaxInt =
    (MaxPacketBits - 1 > (1 << BitsAfterW) - 1) ? (1 << BitsAfterW) - 1 : MaxPacketBits - 1;
  localparam logic [BitsAfterW-1:0] RemMax = RemMaxInt[BitsAfterW-1:0];

  logic [BitsAfterW-1:0] rem;
  parse_state_t          n;
  logic [4:0]            v;
  logic [2:0]            bl;
  logic                  skip_req;
  logic [SkipW-1:0]      skip_n;
  logic                  field_req;
  phase_e                field_phase;
  logic [2:0]            field_w;
  logic [SkipW-1:0]      len;

  assign rem = (item_i.bits_after > RemMax) ? RemMax : item_i.bits_after;

  always_comb begin
    n           = state_i;
    v           = {state_i.shift[3:0], item_i.packet_bit};
    bl          = (state_i.bits_left != 3'd0) ? state_i.bits_left - 3'd1 : 3'd0;
    skip_req    = 1'b0;
    skip_n      = '0;
    field_req   = 1'b0;
    field_phase = PH_FLAG;
    field_w     = '0;
    len         = nb_length(nb_low_i, nb_high_i, v[3:0]);
    case (state_i.phase)
      PH_FLAG: begin
        if (rem < ((state_i.wide_seen == 2'd0) ? 14'd4 : 14'd3)) begin
          n.phase = PH_STOPPED;
          n.stop  = StopOutOfBits;
        end else if (item_i.packet_bit) begin
          if (state_i.wide_seen >= 2'd2) begin
            n.phase = PH_STOPPED;
            n.stop  = StopCorruptWb;
          end else begin
            n.wide_seen = state_i.wide_seen + 2'd1;
            field_req   = 1'b1;
            field_phase = PH_WBMODE;
            field_w     = 3'd3;
          end
        end else begin
          n.wide_seen = 2'd0;
          field_req   = 1'b1;
          field_phase = PH_NBMODE;
          field_w     = 3'd4;
        end
      end
      PH_WBMODE, PH_NBMODE, PH_INBAND, PH_USER: begin
        n.shift     = v;
        n.bits_left = bl;
        if (bl == 3'd0) begin
          case (state_i.phase)
            PH_WBMODE: begin
              if (v >= WbModeLimit) begin
                n.phase = PH_STOPPED;
                n.stop  = StopCorruptWb;
              end else begin
                skip_req = 1'b1;
                skip_n   = wb_advance(v[2:0]);
              end
            end
            PH_NBMODE: begin
              if (v == NbModeTerm) begin
                n.phase = PH_STOPPED;
                n.stop  = StopTerm;
              end else if (v == NbModeInband) begin
                field_req   = 1'b1;
                field_phase = PH_INBAND;
                field_w     = 3'd4;
              end else if (v == NbModeUser) begin
                field_req   = 1'b1;
                field_phase = PH_USER;
                field_w     = 3'd5;
              end else if (v > NbModeMax) begin
                n.phase = PH_STOPPED;
                n.stop  = StopBadMode;
              end else begin
                if (state_i.frames != FrameCountMax) begin
                  n.frames = state_i.frames + 1'b1;
                end
                skip_req = 1'b1;
                skip_n   = (len >= 9'd5) ? len - 9'd5 : 9'd0;
              end
            end
            PH_INBAND: begin
              skip_req = 1'b1;
              skip_n   = inband_len(v[3:0]);
            end
            default: begin
              skip_req = 1'b1;
              skip_n   = {1'b0, v, 3'b000};
            end
          endcase
        end
      end
      PH_SKIP: begin
        n.skip_left = (state_i.skip_left != '0) ? state_i.skip_left - 1'b1 : '0;
        if (n.skip_left == '0) begin
          n.phase = PH_FLAG;
        end
      end
      default: begin
      end
    endcase

    if (field_req) begin
      if (rem < {{(BitsAfterW-3){1'b0}}, field_w}) begin
        n.phase = PH_STOPPED;
        n.stop  = StopOutOfBits;
      end else begin
        n.phase     = field_phase;
        n.shift     = '0;
        n.bits_left = field_w;
      end
    end
    if (skip_req) begin
      if (rem < {{(BitsAfterW-SkipW){1'b0}}, skip_n}) begin
        n.phase = PH_STOPPED;
        n.stop  = StopOutOfBits;
      end else if (skip_n == '0) begin
        n.phase = PH_FLAG;
      end else begin
        n.skip_left = skip_n;
        n.phase     = PH_SKIP;
      end
    end
  end

  assign last_o               = (item_i.bits_after == '0);
  assign result_o.frame_total = n.frames;
  assign result_o.stop_reason = n.stop;
  assign state_o              = last_o ? ParseReset : n;

endmodule

// File: rtl/codec_packet_frame_counter.sv
// Bit-serial packet frame counter: input register, parser state, result register.
// The last bit passes the input register, then its result is loaded into the result
// register and out_valid_o rises; a held result can delay this.
// Throughput: one packet bit per cycle; a held result stalls a full input register.
// Reset clears the parser and the handshake state and loads the default frame
// length tables; no clearing pass is needed.
module codec_packet_frame_counter #(
  parameter int unsigned MaxPacketBits = cpfc_pkg::MaxPacketBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cpfc_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cpfc_pkg::out_item_t            out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cpfc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [cpfc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cpfc_pkg::*;

  logic [NbLowW-1:0]  nb_low_q;
  logic [NbHighW-1:0] nb_high_q;
  in_item_t           in_q;
  logic               in_valid_q, in_valid_d;
  parse_state_t       state_q, state_d;
  out_item_t          out_q, result;
  logic               out_valid_q, out_valid_d;
  logic               advance, last, in_xfer, cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_xfer     = in_valid_i && !in_stall_o;

  cpfc_step #(
    .MaxPacketBits(MaxPacketBits)
  ) u_step (
    .nb_low_i (nb_low_q),
    .nb_high_i(nb_high_q),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (result),
    .last_o   (last)
  );

  always_comb begin
    in_valid_d = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    if (advance && last) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_low_q    <= NbLowReset;
      nb_high_q   <= NbHighReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ParseReset;
    end else begin
      if (cfg_xfer && cfg_index_i == CfgNbLow) begin
        nb_low_q <= cfg_data_i;
      end
      if (cfg_xfer && cfg_index_i == CfgNbHigh) begin
        nb_high_q <= cfg_data_i[NbHighW-1:0];
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_item_i;
    end
    if (advance && last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last) |=> (state_q.phase == PH_FLAG && state_q.frames == '0))
    else $error("parser not cleared after last bit");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a held result");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_SKIP) |-> (state_q.skip_left != '0))
    else $error("skip phase with empty skip count");

  a_wide_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.wide_seen <= 2'd2)
    else $error("too many wideband layers recorded");

endmodule
